/* src/fbpa_pkg.sv */
// ============================================================================
// Fixed block pool allocator package
// Shared widths, reset values, codes and state types of the allocator.
// ============================================================================
package fbpa_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 256;
    localparam int unsigned LINK_BYTES_DEF = 4;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam int ADDR_W        = 32;
    localparam int DATA_BYTES_W  = 8;
    localparam int POOL_BLOCKS_W = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int STATUS_W      = 2;

    localparam logic [ADDR_W-1:0]        BASE_RST        = '0;
    localparam logic [DATA_BYTES_W-1:0]  DATA_BYTES_RST  = 8'd16;
    localparam logic [POOL_BLOCKS_W-1:0] POOL_BLOCKS_RST = 9'd256;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_NULL  = 2'd2,
        STAT_BAD   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE        = 2'd0,
        CFG_DATA_BYTES  = 2'd1,
        CFG_POOL_BLOCKS = 2'd2
    } t_cfg_idx;

    // Command classes handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_NULL  = 2'd1,
        CMD_BAD   = 2'd2,
        CMD_FREE  = 2'd3
    } t_cmd;

    localparam int CMD_W = 2;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ALLOC,
        BK_DIV,
        BK_PUSH
    } t_bk_state;

endpackage

/* src/fbpa_req_if.sv */
// ============================================================================
// Request channel
// Valid/ready channel that carries one allocate or release item.
// ============================================================================
interface fbpa_req_if;
    import fbpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] release_address;

    modport source (output valid, output req_type, output release_address, input ready);
    modport sink   (input valid, input req_type, input release_address, output ready);

endinterface

/* src/fbpa_rsp_if.sv */
// ============================================================================
// Response channel
// Valid/ready channel that carries one result item of the allocator.
// ============================================================================
interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink   (input valid, input granted_address, input status, output ready);

endinterface

/* src/fixed_block_pool_allocator.sv */
// ============================================================================
// Fixed block pool allocator
// LIFO free-list allocator for a pool of equal-sized blocks in memory.
// ============================================================================
// The pool holds pool_blocks blocks (capped at MAX_BLOCKS) starting at
// pool_base_address; each block is LINK_BYTES of link word followed by
// data_bytes of data. An allocate item pops the head of the free list and
// returns its data address, or status "empty". A release item maps the data
// address back to a block index and pushes it; a null address, or an address
// that is misaligned or outside the pool, is reported and ignored. Double
// releases are not detected. Every item yields exactly one result item.
// Items enter a one-stage front that classifies them, then a two-entry
// command queue, then the list engine, which owns the link memory and the
// result register. In the engine a null or bad release or an empty allocate
// goes straight from idle to the result register, an allocate reads the link
// memory once in the ALLOC state, and a valid-range release runs the
// restoring divider, which retires one quotient bit per cycle, then pushes.
// After reset, and after every write to one of the three registers, the free
// list is rebuilt by a clearing pass through the link memory, during which no
// request item is accepted.

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int LINK_BYTES = fbpa_pkg::LINK_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fbpa_req_if.sink                          i_req,
    fbpa_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int BS_W  = $clog2(LINK_BYTES + 256);
    localparam int OFF_W = IDX_W + BS_W;
    localparam int Q_W   = CMD_W + OFF_W;

    // Programmed registers.
    logic [ADDR_W-1:0]        r_base;
    logic [DATA_BYTES_W-1:0]  r_data_bytes;
    logic [POOL_BLOCKS_W-1:0] r_pool_blocks;
    logic                     r_rebuild;

    // Values derived from the registers, registered from them in the cycle after. The rebuild
    // pulse is registered as well, so the clearing pass sees the new values.
    logic [ADDR_W-1:0]        r_base_data;
    logic [BS_W-1:0]          r_bs;
    logic [CNT_W-1:0]         r_count;
    logic [OFF_W-1:0]         r_span;

    logic [CNT_W-1:0]         count_c;
    logic [BS_W-1:0]          bs_c;
    logic [CNT_W+BS_W-1:0]    span_c;
    logic                     cfg_hit;

    logic                     fr_valid, fr_ready;
    t_cmd                     fr_cmd;
    logic [OFF_W-1:0]         fr_off;
    logic                     q_valid, q_ready;
    logic [Q_W-1:0]           q_data;
    logic                     bk_busy;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_BASE || i_cfg_idx == CFG_DATA_BYTES
                                  || i_cfg_idx == CFG_POOL_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= BASE_RST;
            r_data_bytes  <= DATA_BYTES_RST;
            r_pool_blocks <= POOL_BLOCKS_RST;
            r_rebuild     <= 1'b1;
        end else begin
            r_rebuild <= cfg_hit;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE:        r_base        <= i_cfg_data;
                    CFG_DATA_BYTES:  r_data_bytes  <= i_cfg_data[DATA_BYTES_W-1:0];
                    CFG_POOL_BLOCKS: r_pool_blocks <= i_cfg_data[POOL_BLOCKS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // A block count above the memory depth is taken as the depth.
    assign count_c = (32'(r_pool_blocks) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                            : CNT_W'(r_pool_blocks);
    assign bs_c    = BS_W'(LINK_BYTES) + BS_W'(r_data_bytes);
    assign span_c  = (CNT_W + BS_W)'(count_c) * (CNT_W + BS_W)'(bs_c);

    always_ff @(posedge i_clk) begin
        r_base_data <= r_base + ADDR_W'(LINK_BYTES);
        r_bs        <= bs_c;
        r_count     <= count_c;
        r_span      <= span_c[OFF_W-1:0];
    end

    fbpa_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .LINK_BYTES (LINK_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_enable     (!bk_busy && !r_rebuild),
        .i_base_data  (r_base_data),
        .i_span       (r_span),
        .o_push_valid (fr_valid),
        .i_push_ready (fr_ready),
        .o_cmd        (fr_cmd),
        .o_off        (fr_off)
    );

    fbpa_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_data  ({fr_cmd, fr_off}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    fbpa_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .LINK_BYTES (LINK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rebuild   (r_rebuild),
        .i_count     (r_count),
        .i_bs        (r_bs),
        .i_base_data (r_base_data),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (t_cmd'(q_data[OFF_W +: CMD_W])),
        .i_off       (q_data[OFF_W-1:0]),
        .o_busy      (bk_busy),
        .o_rsp       (o_rsp)
    );

endmodule

/* src/fbpa_ram.sv */
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fbpa_queue.sv */
// ============================================================================
// Command queue
// Small FIFO that decouples the classifying front from the list engine.
// ============================================================================
module fbpa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_data[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wptr] <= i_push_data;
        end
    end

endmodule

/* src/fbpa_front.sv */
// ============================================================================
// Request front
// Accepts request items, classifies them and computes the pool offset.
// ============================================================================
module fbpa_front #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int LINK_BYTES = fbpa_pkg::LINK_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fbpa_req_if.sink                  i_req,
    input  logic                      i_enable,
    input  logic [fbpa_pkg::ADDR_W-1:0] i_base_data,
    input  logic [$clog2(MAX_BLOCKS)+$clog2(LINK_BYTES+256)-1:0] i_span,
    output logic                      o_push_valid,
    input  logic                      i_push_ready,
    output fbpa_pkg::t_cmd            o_cmd,
    output logic [$clog2(MAX_BLOCKS)+$clog2(LINK_BYTES+256)-1:0] o_off
);
    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int BS_W  = $clog2(LINK_BYTES + 256);
    localparam int OFF_W = IDX_W + BS_W;

    logic              r_valid;
    t_cmd              r_cmd;
    logic [OFF_W-1:0]  r_off;
    logic [ADDR_W-1:0] off_full;
    t_cmd              cls;
    logic              accept;

    assign i_req.ready = i_enable && (!r_valid || i_push_ready);
    assign accept      = i_req.valid && i_req.ready;
    assign off_full    = i_req.release_address - i_base_data;

    // An offset at or past the pool span cannot name a block, so such a
    // release is rejected here and never reaches the divider.
    always_comb begin
        priority if (i_req.req_type == REQ_ALLOC) begin
            cls = CMD_ALLOC;
        end else if (i_req.release_address == '0) begin
            cls = CMD_NULL;
        end else if (off_full >= ADDR_W'(i_span)) begin
            cls = CMD_BAD;
        end else begin
            cls = CMD_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cls;
            r_off <= off_full[OFF_W-1:0];
        end
    end

    assign o_push_valid = r_valid;
    assign o_cmd        = r_cmd;
    assign o_off        = r_off;

endmodule

/* src/fbpa_back.sv */
// ============================================================================
// List engine
// Owns the free list: rebuilds it, pops for allocations, divides and pushes
// for releases, and holds the result item in an output register.
// ============================================================================
module fbpa_back #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int LINK_BYTES = fbpa_pkg::LINK_BYTES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rebuild,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]       i_count,
    input  logic [$clog2(LINK_BYTES+256)-1:0]     i_bs,
    input  logic [fbpa_pkg::ADDR_W-1:0]           i_base_data,
    input  logic                                  i_cmd_valid,
    output logic                                  o_cmd_ready,
    input  fbpa_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_BLOCKS)+$clog2(LINK_BYTES+256)-1:0] i_off,
    output logic                                  o_busy,
    fbpa_rsp_if.source                            o_rsp
);
    import fbpa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int BS_W   = $clog2(LINK_BYTES + 256);
    localparam int OFF_W  = IDX_W + BS_W;
    localparam int STEP_W = $clog2(IDX_W + 1);
    localparam int WORD_W = IDX_W + 1;

    t_bk_state         r_state, n_state;
    logic [IDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic [IDX_W-1:0]  r_head, n_head;
    logic              r_head_valid, n_head_valid;
    logic [BS_W-1:0]   r_rem, n_rem;
    logic [IDX_W-1:0]  r_quo, n_quo;
    logic [STEP_W-1:0] r_step, n_step;
    logic [OFF_W-1:0]  r_prod, n_prod;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    t_status           r_out_status, n_out_status;

    logic              pop;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [IDX_W:0]    clr_next;
    logic [BS_W:0]     trial;
    logic              qbit;

    fbpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A command is taken only when the output register will be free.
    assign o_cmd_ready = (r_state == BK_IDLE) && !i_rebuild && (!r_out_valid || o_rsp.ready);
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign o_busy      = (r_state == BK_CLEAR);

    assign clr_next = (IDX_W + 1)'(r_clr_idx) + 1'b1;
    assign trial    = {r_rem, r_quo[IDX_W-1]};
    assign qbit     = (trial >= (BS_W + 1)'(i_bs));

    always_comb begin
        n_state = r_state;
        if (i_rebuild) begin
            n_state = BK_CLEAR;
        end else begin
            unique case (r_state)
                BK_CLEAR: begin
                    if (r_clr_idx == IDX_W'(MAX_BLOCKS - 1)) begin
                        n_state = BK_IDLE;
                    end
                end
                BK_IDLE: begin
                    if (pop && i_cmd == CMD_ALLOC && r_head_valid) begin
                        n_state = BK_ALLOC;
                    end else if (pop && i_cmd == CMD_FREE) begin
                        n_state = BK_DIV;
                    end
                end
                BK_ALLOC: n_state = BK_IDLE;
                BK_DIV: begin
                    if (r_step == STEP_W'(IDX_W - 1)) begin
                        n_state = BK_PUSH;
                    end
                end
                BK_PUSH:  n_state = BK_IDLE;
                default:  n_state = BK_CLEAR;
            endcase
        end
    end

    always_comb begin
        n_clr_idx    = r_clr_idx;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_step       = r_step;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_clr_idx;
        ram_wdata    = {clr_next < (IDX_W + 1)'(i_count), clr_next[IDX_W-1:0]};
        ram_re       = 1'b0;
        ram_raddr    = r_head;

        if (i_rebuild) begin
            n_clr_idx = '0;
        end else begin
            unique case (r_state)
                BK_CLEAR: begin
                    // Entry i links to i+1; the last block of the pool ends it.
                    ram_we    = 1'b1;
                    n_clr_idx = clr_next[IDX_W-1:0];
                    if (r_clr_idx == IDX_W'(MAX_BLOCKS - 1)) begin
                        n_head       = '0;
                        n_head_valid = (i_count != '0);
                    end
                end
                BK_IDLE: begin
                    if (pop) begin
                        unique case (i_cmd)
                            CMD_ALLOC: begin
                                if (r_head_valid) begin
                                    ram_re = 1'b1;
                                    n_prod = OFF_W'(r_head * i_bs);
                                end else begin
                                    n_out_valid  = 1'b1;
                                    n_out_addr   = '0;
                                    n_out_status = STAT_EMPTY;
                                end
                            end
                            CMD_NULL: begin
                                n_out_valid  = 1'b1;
                                n_out_addr   = '0;
                                n_out_status = STAT_NULL;
                            end
                            CMD_BAD: begin
                                n_out_valid  = 1'b1;
                                n_out_addr   = '0;
                                n_out_status = STAT_BAD;
                            end
                            CMD_FREE: begin
                                n_rem  = i_off[OFF_W-1:IDX_W];
                                n_quo  = i_off[IDX_W-1:0];
                                n_step = '0;
                            end
                            default: ;
                        endcase
                    end
                end
                BK_ALLOC: begin
                    n_head       = ram_rdata[IDX_W-1:0];
                    n_head_valid = ram_rdata[IDX_W];
                    n_out_valid  = 1'b1;
                    n_out_addr   = i_base_data + ADDR_W'(r_prod);
                    n_out_status = STAT_OK;
                end
                BK_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    n_rem  = qbit ? BS_W'(trial - (BS_W + 1)'(i_bs)) : trial[BS_W-1:0];
                    n_quo  = (r_quo << 1) | IDX_W'(qbit);
                    n_step = r_step + 1'b1;
                end
                BK_PUSH: begin
                    n_out_valid = 1'b1;
                    n_out_addr  = '0;
                    if (r_rem != '0) begin
                        n_out_status = STAT_BAD;
                    end else begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_quo;
                        ram_wdata    = {r_head_valid, r_head};
                        n_head       = r_quo;
                        n_head_valid = 1'b1;
                        n_out_status = STAT_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_CLEAR;
            r_clr_idx    <= '0;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_step       <= n_step;
        r_prod       <= n_prod;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.granted_address = r_out_addr;
    assign o_rsp.status          = r_out_status;

    a_out_free_while_working: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_ALLOC || r_state == BK_DIV || r_state == BK_PUSH) |-> !r_out_valid)
        else $error("result register busy while a command is in progress");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV || r_state == BK_PUSH) |-> (r_rem < i_bs))
        else $error("partial remainder not below block size");

    a_push_inside_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_PUSH && r_rem == '0) |-> ((IDX_W + 1)'(r_quo) < (IDX_W + 1)'(i_count)))
        else $error("released block index outside the pool");

    a_rebuild_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rebuild |=> (r_state == BK_CLEAR && r_clr_idx == '0))
        else $error("rebuild did not restart the clearing pass");

endmodule
